// ----- design/swt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt_pkg
// Shared types and constants of the software timer event table.
// ----------------------------------------------------------------------------
package swt_pkg;

  localparam int unsigned ID_W   = 5;
  localparam int unsigned TIME_W = 32;
  localparam logic [TIME_W-1:0] ALL_ONES = '1;

  typedef enum logic [2:0] {
    OP_CREATE     = 3'd0,
    OP_ACTIVATE   = 3'd1,
    OP_DEACTIVATE = 3'd2,
    OP_SET_DELAY  = 3'd3,
    OP_QUERY      = 3'd4,
    OP_TICK       = 3'd5,
    OP_SCAN       = 3'd6
  } op_e;

  typedef struct packed {
    op_e               operation;
    logic [3:0]        event_id;
    logic [TIME_W-1:0] delay_ms;
    logic              has_handler;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]   slot_id;
    logic [TIME_W-1:0] remaining_ms;
    logic              fired;
    logic              last;
  } result_t;

  typedef struct packed {
    logic create;
    logic arm;
    logic arm_delay;
    logic disarm;
    logic tick;
    logic probe;
    logic probe_scan;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } stat_t;

endpackage

// ----- design/swt_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt_dpath
// Slot store, time counter, probe pipeline and result register.
// ----------------------------------------------------------------------------
module swt_dpath import swt_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 16,
  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  item_t           item_i,
  input  cmd_t            cmd_i,
  input  logic [IdxW-1:0] probe_idx_i,
  output stat_t           stat_o,
  output logic [CntW-1:0] count_o,
  output result_t         result_o,
  output logic            result_valid_o
);

  logic [TIME_W-1:0]     now_q;
  logic [CntW-1:0]       count_q;
  logic [SLOT_COUNT-1:0] active_q, active_d;
  logic [SLOT_COUNT-1:0] handler_q, handler_d;

  logic [TIME_W-1:0] start_mem [SLOT_COUNT];
  logic [TIME_W-1:0] delay_mem [SLOT_COUNT];

  logic              s1_vld_q, s1_scan_q, s1_ok_q;
  logic [IdxW-1:0]   s1_idx_q;
  logic [TIME_W-1:0] rd_start_q, rd_delay_q;
  logic              s2_vld_q, s2_scan_q, s2_ok_q;
  logic [IdxW-1:0]   s2_idx_q;
  logic [TIME_W-1:0] el_q, dly_q;

  logic              pend_vld_q, pend_vld_d;
  logic [IdxW-1:0]   pend_idx_q, pend_idx_d;
  result_t           res_q, res_d;
  logic              res_vld_q, res_vld_d;

  logic              id_ok, has_room, s1_ok_d, hit, q_live;
  logic [IdxW-1:0]   id_idx, new_idx;
  logic [TIME_W-1:0] q_rem;

  assign id_ok    = 32'(item_i.event_id) < 32'(count_q);
  assign has_room = count_q < CntW'(SLOT_COUNT);
  assign id_idx   = IdxW'(item_i.event_id);
  assign new_idx  = IdxW'(count_q);

  always_comb begin
    active_d  = active_q;
    handler_d = handler_q;
    if (cmd_i.create && has_room) begin
      active_d[new_idx]  = 1'b0;
      handler_d[new_idx] = item_i.has_handler;
    end
    if (cmd_i.arm && id_ok) begin
      active_d[id_idx] = 1'b1;
    end
    if (cmd_i.disarm && id_ok) begin
      active_d[id_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q     <= '0;
      count_q   <= '0;
      active_q  <= '0;
      handler_q <= '0;
    end else begin
      active_q  <= active_d;
      handler_q <= handler_d;
      if (cmd_i.tick) begin
        now_q <= now_q + TIME_W'(1);
      end
      if (cmd_i.create && has_room) begin
        count_q <= count_q + CntW'(1);
      end
    end
  end

  // slot store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.arm && id_ok) begin
      start_mem[id_idx] <= now_q;
      delay_mem[id_idx] <= cmd_i.arm_delay ? item_i.delay_ms : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe) begin
      rd_start_q <= start_mem[probe_idx_i];
      rd_delay_q <= delay_mem[probe_idx_i];
    end
  end

  assign s1_ok_d = cmd_i.probe_scan ?
                   (active_q[probe_idx_i] & handler_q[probe_idx_i]) :
                   (id_ok & active_q[probe_idx_i]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.probe;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_scan_q <= cmd_i.probe_scan;
    s1_ok_q   <= s1_ok_d;
    s1_idx_q  <= probe_idx_i;
    s2_scan_q <= s1_scan_q;
    s2_ok_q   <= s1_ok_q;
    s2_idx_q  <= s1_idx_q;
    el_q      <= now_q - rd_start_q;
    dly_q     <= rd_delay_q;
  end

  assign hit    = s2_vld_q && s2_scan_q && s2_ok_q && (el_q >= dly_q);
  assign q_live = s2_ok_q && (dly_q > el_q);
  assign q_rem  = q_live ? (dly_q - el_q) : ALL_ONES;

  always_comb begin
    pend_vld_d = pend_vld_q;
    pend_idx_d = pend_idx_q;
    res_vld_d  = 1'b0;
    res_d      = res_q;
    priority if (cmd_i.create) begin
      res_vld_d = 1'b1;
      res_d     = '{slot_id: has_room ? ID_W'(count_q) : ID_W'(SLOT_COUNT),
                    remaining_ms: '0, fired: 1'b0, last: 1'b1};
    end else if (s2_vld_q && !s2_scan_q) begin
      res_vld_d = 1'b1;
      res_d     = '{slot_id: '0, remaining_ms: q_rem, fired: 1'b0, last: 1'b1};
    end else if (hit) begin
      pend_vld_d = 1'b1;
      pend_idx_d = s2_idx_q;
      if (pend_vld_q) begin
        res_vld_d = 1'b1;
        res_d     = '{slot_id: ID_W'(pend_idx_q), remaining_ms: '0,
                      fired: 1'b1, last: 1'b0};
      end
    end else if (cmd_i.flush) begin
      pend_vld_d = 1'b0;
      res_vld_d  = 1'b1;
      res_d      = '{slot_id: pend_vld_q ? ID_W'(pend_idx_q) : '0,
                     remaining_ms: '0, fired: pend_vld_q, last: 1'b1};
    end else begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    res_q      <= res_d;
  end

  assign stat_o.pipe_busy = s1_vld_q | s2_vld_q;
  assign count_o          = count_q;
  assign result_o         = res_q;
  assign result_valid_o   = res_vld_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(SLOT_COUNT))
    else $error("created count beyond table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush && pend_vld_q |=> res_vld_q && res_q.last && res_q.fired)
    else $error("held hit not delivered as final beat");

endmodule

// ----- design/swt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt_ctrl
// Command decode and scan sequencer of the software timer event table.
// ----------------------------------------------------------------------------
module swt_ctrl import swt_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 16,
  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  item_t           item_i,
  input  stat_t           stat_i,
  input  logic [CntW-1:0] count_i,
  output logic            busy_o,
  output cmd_t            cmd_o,
  output logic [IdxW-1:0] probe_idx_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            scan_q, scan_d;
  logic            accept;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    scan_d      = scan_q;
    cmd_o       = '0;
    probe_idx_o = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (item_i.operation)
            OP_CREATE:     cmd_o.create = 1'b1;
            OP_ACTIVATE:   cmd_o.arm = 1'b1;
            OP_SET_DELAY: begin
              cmd_o.arm       = 1'b1;
              cmd_o.arm_delay = 1'b1;
            end
            OP_DEACTIVATE: cmd_o.disarm = 1'b1;
            OP_TICK:       cmd_o.tick = 1'b1;
            OP_QUERY: begin
              cmd_o.probe = 1'b1;
              probe_idx_o = IdxW'(item_i.event_id);
              scan_d      = 1'b0;
              state_d     = ST_DRAIN;
            end
            OP_SCAN: begin
              scan_d  = 1'b1;
              cnt_d   = '0;
              state_d = (count_i == '0) ? ST_FLUSH : ST_PROBE;
            end
            default: ;
          endcase
        end
      end
      ST_PROBE: begin
        cmd_o.probe      = 1'b1;
        cmd_o.probe_scan = 1'b1;
        cnt_d            = cnt_q + IdxW'(1);
        if (CntW'(cnt_q) + CntW'(1) == count_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = scan_q ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      scan_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      scan_q  <= scan_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PROBE |-> CntW'(cnt_q) < count_i)
    else $error("scan probe past created slots");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH |=> state_q == ST_IDLE && $past(scan_q))
    else $error("flush outside a scan");

endmodule

// ----- design/software_timer_event_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_event_table
// Table of one-shot millisecond timers with create, arm, query and scan.
// ----------------------------------------------------------------------------
// channel   ports                      beat taken when
// input     start_i, busy_o, item_i    start_i high and busy_o low
// result    result_valid_o, result_o   result_valid_o high (one cycle)
//
// Create, activate, deactivate, set_delay and tick are taken without raising busy_o.
// Query and scan raise busy_o; scan probes one slot per cycle through the
// single read port, or goes straight to flush when no slot exists.
// Results appear in the cycle after they are formed and cannot be stalled.
// Reset clears the time counter, slot count and all active/handler bits.
// ----------------------------------------------------------------------------
module software_timer_event_table import swt_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  output logic    busy_o,
  input  item_t   item_i,
  output result_t result_o,
  output logic    result_valid_o
);

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);

  cmd_t            cmd;
  stat_t           stat;
  logic [IdxW-1:0] probe_idx;
  logic [CntW-1:0] count;

  swt_ctrl #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .stat_i     (stat),
    .count_i    (count),
    .busy_o     (busy_o),
    .cmd_o      (cmd),
    .probe_idx_o(probe_idx)
  );

  swt_dpath #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_i),
    .cmd_i         (cmd),
    .probe_idx_i   (probe_idx),
    .stat_o        (stat),
    .count_o       (count),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

endmodule

// ----- tb/software_timer_event_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_event_table_tb
// Self-checking bench for the timer event table. A behavioral copy of the
// table predicts every result beat. Directed tests cover the empty table,
// the first timers and a full table. Random traffic follows with sender
// gaps of 13 %, 84 % and 0 %. Each result beat is compared field by field.
// ----------------------------------------------------------------------------
module software_timer_event_table_tb;
  import swt_pkg::*;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned HANG_LIMIT = 5000;
  localparam int unsigned DRAIN_WAIT = 40;

  logic    clk_i;
  logic    rst_ni;
  logic    start_i;
  logic    busy_o;
  item_t   item_i;
  result_t result_o;
  logic    result_valid_o;

  software_timer_event_table #(
    .SLOT_COUNT(SLOTS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .item_i        (item_i),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // behavioral copy of the table
  logic [TIME_W-1:0] clock_ms;
  int unsigned       slot_count;
  bit                armed       [SLOTS];
  bit                has_cb      [SLOTS];
  logic [TIME_W-1:0] armed_at    [SLOTS];
  logic [TIME_W-1:0] armed_delay [SLOTS];
  result_t           timer_replies[$];

  int unsigned err_count;
  int unsigned gap_pct;
  int unsigned quiet_cycles;

  function automatic result_t make_reply(input int unsigned id, input logic [TIME_W-1:0] rem,
                                         input logic fired, input logic last);
    result_t r;
    r.slot_id      = ID_W'(id);
    r.remaining_ms = rem;
    r.fired        = fired;
    r.last         = last;
    return r;
  endfunction

  function automatic item_t make_item(input op_e op, input logic [3:0] id,
                                      input logic [TIME_W-1:0] dly, input logic cb);
    item_t it;
    it.operation   = op;
    it.event_id    = id;
    it.delay_ms    = dly;
    it.has_handler = cb;
    return it;
  endfunction

  task automatic apply_timer_cmd(input item_t it);
    bit                in_use;
    logic [TIME_W-1:0] el;
    logic [TIME_W-1:0] rem;
    result_t           held;
    int unsigned       hits;
    in_use = (it.event_id < slot_count);
    case (it.operation)
      OP_CREATE: begin
        if (slot_count < SLOTS) begin
          armed[slot_count]  = 1'b0;
          has_cb[slot_count] = it.has_handler;
          timer_replies.push_back(make_reply(slot_count, '0, 1'b0, 1'b1));
          slot_count++;
        end else begin
          timer_replies.push_back(make_reply(SLOTS, '0, 1'b0, 1'b1));
        end
      end
      OP_ACTIVATE, OP_SET_DELAY: begin
        if (in_use) begin
          armed_at[it.event_id]    = clock_ms;
          armed_delay[it.event_id] = (it.operation == OP_SET_DELAY) ? it.delay_ms : '0;
          armed[it.event_id]       = 1'b1;
        end
      end
      OP_DEACTIVATE: begin
        if (in_use) armed[it.event_id] = 1'b0;
      end
      OP_QUERY: begin
        rem = ALL_ONES;
        if (in_use && armed[it.event_id]) begin
          el = clock_ms - armed_at[it.event_id];
          if (armed_delay[it.event_id] > el) rem = armed_delay[it.event_id] - el;
        end
        timer_replies.push_back(make_reply(0, rem, 1'b0, 1'b1));
      end
      OP_TICK: begin
        clock_ms = clock_ms + 1'b1;
      end
      OP_SCAN: begin
        hits = 0;
        for (int unsigned s = 0; s < slot_count; s++) begin
          el = clock_ms - armed_at[s];
          if (armed[s] && has_cb[s] && el >= armed_delay[s]) begin
            if (hits != 0) timer_replies.push_back(held);
            held = make_reply(s, '0, 1'b1, 1'b0);
            hits++;
          end
        end
        if (hits == 0) begin
          timer_replies.push_back(make_reply(0, '0, 1'b0, 1'b1));
        end else begin
          held.last = 1'b1;
          timer_replies.push_back(held);
        end
      end
      default: ;
    endcase
  endtask

  // one input beat; called in the time step of a rising edge
  task automatic send_beat(input item_t it);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    apply_timer_cmd(it);
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (timer_replies.size() == 0) begin
        $error("unexpected result beat: slot_id %0d remaining_ms %0h",
               result_o.slot_id, result_o.remaining_ms);
        err_count++;
      end else begin
        want = timer_replies.pop_front();
        if (result_o.slot_id !== want.slot_id) begin
          $error("slot_id expected %0d actual %0d", want.slot_id, result_o.slot_id);
          err_count++;
        end
        if (result_o.remaining_ms !== want.remaining_ms) begin
          $error("remaining_ms expected %0h actual %0h", want.remaining_ms,
                 result_o.remaining_ms);
          err_count++;
        end
        if (result_o.fired !== want.fired) begin
          $error("fired expected %0b actual %0b", want.fired, result_o.fired);
          err_count++;
        end
        if (result_o.last !== want.last) begin
          $error("last expected %0b actual %0b", want.last, result_o.last);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && busy_o === 1'b0) || result_valid_o === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic test_empty_table();
    send_beat(make_item(OP_SCAN, 4'd0, '0, 1'b0));
    send_beat(make_item(OP_QUERY, 4'd5, '0, 1'b1));
    send_beat(make_item(OP_ACTIVATE, 4'd3, '1, 1'b1));
  endtask

  task automatic test_first_timers();
    send_beat(make_item(OP_CREATE, 4'd0, '0, 1'b1));
    send_beat(make_item(OP_CREATE, 4'd0, '0, 1'b0));
    send_beat(make_item(OP_CREATE, 4'd15, '1, 1'b1));
    send_beat(make_item(OP_QUERY, 4'd0, '0, 1'b0));
    send_beat(make_item(OP_ACTIVATE, 4'd0, '1, 1'b0));
    send_beat(make_item(OP_SET_DELAY, 4'd1, '0, 1'b1));
    send_beat(make_item(OP_SET_DELAY, 4'd2, '1, 1'b0));
    send_beat(make_item(OP_QUERY, 4'd2, '0, 1'b0));
    send_beat(make_item(OP_TICK, 4'd0, '0, 1'b0));
    send_beat(make_item(OP_QUERY, 4'd0, '0, 1'b0));
    send_beat(make_item(OP_SCAN, 4'd0, '0, 1'b0));
    send_beat(make_item(OP_DEACTIVATE, 4'd0, '0, 1'b0));
    send_beat(make_item(OP_SCAN, 4'd15, '1, 1'b1));
  endtask

  task automatic test_table_full();
    while (slot_count < SLOTS)
      send_beat(make_item(OP_CREATE, 4'($urandom), $urandom, $urandom_range(3) != 0));
    send_beat(make_item(OP_CREATE, 4'($urandom), $urandom, 1'b1));
  endtask

  function automatic op_e pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3)  return OP_CREATE;
    if (r < 13) return OP_ACTIVATE;
    if (r < 21) return OP_DEACTIVATE;
    if (r < 43) return OP_SET_DELAY;
    if (r < 60) return OP_QUERY;
    if (r < 85) return OP_TICK;
    return OP_SCAN;
  endfunction

  function automatic logic [TIME_W-1:0] pick_delay();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) return $urandom_range(6);
    if (r < 8) return $urandom;
    if (r < 9) return ALL_ONES - $urandom_range(3);
    return $urandom_range(40);
  endfunction

  task automatic test_random_traffic(input int unsigned beats, input int unsigned pct);
    gap_pct = pct;
    repeat (beats)
      send_beat(make_item(pick_op(), 4'($urandom), pick_delay(), 1'($urandom)));
  endtask

  initial begin
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    item_i       <= '0;
    err_count    = 0;
    gap_pct      = 0;
    quiet_cycles = 0;
    clock_ms     = '0;
    slot_count   = 0;
    for (int s = 0; s < SLOTS; s++) begin
      armed[s]       = 1'b0;
      has_cb[s]      = 1'b0;
      armed_at[s]    = '0;
      armed_delay[s] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_first_timers();
    test_table_full();
    test_random_traffic(50, 13);
    test_random_traffic(40, 84);
    test_random_traffic(50, 0);

    start_i <= 1'b0;
    while (timer_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
